// ===== hdl/lrupr_pkg.sv =====
// LRU page replacement: shared constants and control structs.
// Used by lrupr_cell and lru_page_replacement_unit; depends on nothing.
`timescale 1ns / 1ps

package lrupr_pkg;

  localparam int FRAME_COUNT_DEF = 16;
  localparam int PAGE_BITS_DEF   = 16;

  localparam int PAGE_PORT_W  = 16;
  localparam int SLOT_PORT_W  = 4;
  localparam int FAULT_W      = 32;
  localparam int CFG_W        = 5;

  localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  typedef struct packed {
    logic active;
    logic hit;
    logic best_valid;
  } scan_ctl_t;

  typedef struct packed {
    logic flush;
    logic touch;
    logic write;
  } cell_cmd_t;

endpackage

// ===== hdl/lru_page_replacement_unit.sv =====
// LRU page replacement unit: top level with the chain of frame cells.
// Depends on lrupr_pkg and lrupr_cell.
//
// Usage:
//   Raise start_i with page_number_i; the item is taken at a clock edge where
//   start_i is high and busy_o is low. busy_o stays high until the result.
//   The lookup walks the chain of FRAME_COUNT cells, one cell per cycle, and the
//   result is registered after the tail cell; busy_o falls as result_valid_o
//   rises, so a new item can already be taken at the edge that ends the result.
//   Only one item is in the chain at a time.
//   The result (hit_o, frame_slot_o, evicted_o, evicted_page_o, fault_total_o)
//   is shown for exactly one cycle with result_valid_o high; the receiver
//   cannot stall it, so it must take it in that cycle.
//   The frame count is written on cfg_data_i with cfg_valid_i while
//   cfg_ready_o is high (block idle); a write flushes the frame table and
//   keeps the fault count. Values 0 act as 1, values above FRAME_COUNT act
//   as FRAME_COUNT.
//   Reset empties the table, sets the frame count to 16 (clamped) and clears
//   the fault count.
`timescale 1ns / 1ps

module lru_page_replacement_unit
  import lrupr_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int PAGE_BITS   = PAGE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [PAGE_PORT_W-1:0] page_number_i,
  output logic                   result_valid_o,
  output logic                   hit_o,
  output logic [SLOT_PORT_W-1:0] frame_slot_o,
  output logic                   evicted_o,
  output logic [PAGE_PORT_W-1:0] evicted_page_o,
  output logic [FAULT_W-1:0]     fault_total_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  localparam int SLOT_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CNT_W  = $clog2(FRAME_COUNT + 1);
  localparam logic [CNT_W-1:0] E_RESET =
    (int'(CFG_RESET) > FRAME_COUNT) ? CNT_W'(FRAME_COUNT) : CNT_W'(CFG_RESET);

  logic                 busy_q;
  logic                 launch_q;
  logic [PAGE_BITS-1:0] key_q;
  logic [CNT_W-1:0]     e_q, e_d;
  logic [CNT_W-1:0]     filled_q;
  logic [FAULT_W-1:0]   fault_q;
  logic                 accept;
  logic                 cfg_write;

  scan_ctl_t            ctl       [0:FRAME_COUNT];
  logic [SLOT_W-1:0]    hit_slot  [0:FRAME_COUNT];
  logic [SLOT_W-1:0]    hit_rank  [0:FRAME_COUNT];
  logic [SLOT_W-1:0]    fill_rank [0:FRAME_COUNT];
  logic [SLOT_W-1:0]    best_rank [0:FRAME_COUNT];
  logic [SLOT_W-1:0]    best_slot [0:FRAME_COUNT];
  logic [PAGE_BITS-1:0] best_page [0:FRAME_COUNT];

  cell_cmd_t            cmd;
  logic [SLOT_W-1:0]    cmd_slot;
  logic [SLOT_W-1:0]    cmd_rank;
  scan_ctl_t            tail;
  logic                 do_fill;
  logic                 do_evict;

  logic                 result_valid_q;
  logic                 hit_q;
  logic [SLOT_PORT_W-1:0] slot_q;
  logic                 evicted_q;
  logic [PAGE_PORT_W-1:0] evicted_page_q;

  assign accept    = start_i && !busy_q;
  assign cfg_write = cfg_valid_i && !busy_q;

  always_comb begin
    if (cfg_data_i == '0) begin
      e_d = CNT_W'(1);
    end else if (32'(cfg_data_i) > FRAME_COUNT) begin
      e_d = CNT_W'(FRAME_COUNT);
    end else begin
      e_d = CNT_W'(cfg_data_i);
    end
  end

  // head of the chain
  assign ctl[0]       = '{active: launch_q, hit: 1'b0, best_valid: 1'b0};
  assign hit_slot[0]  = '0;
  assign hit_rank[0]  = '0;
  assign fill_rank[0] = '0;
  assign best_rank[0] = '0;
  assign best_slot[0] = '0;
  assign best_page[0] = '0;

  for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
    lrupr_cell #(
      .SLOT   (g),
      .SLOT_W (SLOT_W),
      .CNT_W  (CNT_W),
      .PAGE_W (PAGE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .e_i         (e_q),
      .fill_idx_i  (filled_q),
      .key_i       (key_q),
      .cmd_i       (cmd),
      .cmd_slot_i  (cmd_slot),
      .cmd_rank_i  (cmd_rank),
      .cmd_page_i  (key_q),
      .ctl_i       (ctl[g]),
      .hit_slot_i  (hit_slot[g]),
      .hit_rank_i  (hit_rank[g]),
      .fill_rank_i (fill_rank[g]),
      .best_rank_i (best_rank[g]),
      .best_slot_i (best_slot[g]),
      .best_page_i (best_page[g]),
      .ctl_o       (ctl[g+1]),
      .hit_slot_o  (hit_slot[g+1]),
      .hit_rank_o  (hit_rank[g+1]),
      .fill_rank_o (fill_rank[g+1]),
      .best_rank_o (best_rank[g+1]),
      .best_slot_o (best_slot[g+1]),
      .best_page_o (best_page[g+1])
    );
  end

  // resolve the item at the tail of the chain
  assign tail     = ctl[FRAME_COUNT];
  assign do_fill  = !tail.hit && (filled_q < e_q);
  assign do_evict = !tail.hit && !do_fill && tail.best_valid;

  always_comb begin
    cmd       = '0;
    cmd.flush = cfg_write;
    cmd.touch = tail.active;
    cmd.write = tail.active && !tail.hit;
    if (tail.hit) begin
      cmd_slot = hit_slot[FRAME_COUNT];
      cmd_rank = hit_rank[FRAME_COUNT];
    end else if (do_fill) begin
      cmd_slot = SLOT_W'(filled_q);
      cmd_rank = fill_rank[FRAME_COUNT];
    end else begin
      cmd_slot = best_slot[FRAME_COUNT];
      cmd_rank = best_rank[FRAME_COUNT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q         <= 1'b0;
      launch_q       <= 1'b0;
      e_q            <= E_RESET;
      filled_q       <= '0;
      fault_q        <= '0;
      result_valid_q <= 1'b0;
    end else begin
      launch_q       <= accept;
      result_valid_q <= tail.active;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (tail.active) begin
        busy_q <= 1'b0;
      end
      if (cfg_write) begin
        e_q      <= e_d;
        filled_q <= '0;
      end else if (tail.active && do_fill) begin
        filled_q <= filled_q + 1'b1;
      end
      if (tail.active && !tail.hit && (fault_q != FAULT_MAX)) begin
        fault_q <= fault_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= PAGE_BITS'(page_number_i);
    end
    if (tail.active) begin
      hit_q          <= tail.hit;
      slot_q         <= SLOT_PORT_W'(cmd_slot);
      evicted_q      <= do_evict;
      evicted_page_q <= do_evict ? PAGE_PORT_W'(best_page[FRAME_COUNT]) : '0;
    end
  end

  assign busy_o         = busy_q;
  assign cfg_ready_o    = !busy_q;
  assign result_valid_o = result_valid_q;
  assign hit_o          = hit_q;
  assign frame_slot_o   = slot_q;
  assign evicted_o      = evicted_q;
  assign evicted_page_o = evicted_page_q;
  assign fault_total_o  = fault_q;

  a_tail_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.active |=> result_valid_q)
    else $error("scan reached the tail without a result");

  a_result_frees_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |-> !busy_q)
    else $error("unit still busy while showing a result");

  a_hit_keeps_faults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q && hit_q |-> $stable(fault_q))
    else $error("fault count moved on a hit");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= e_q)
    else $error("fill count beyond frame count");

  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q && evicted_q |-> !hit_q)
    else $error("eviction reported on a hit");

endmodule

// ===== hdl/lrupr_cell.sv =====
// LRU page replacement: one frame cell holding page, valid bit and recency rank.
// Passes the lookup scan to its neighbor each cycle; depends on lrupr_pkg.
`timescale 1ns / 1ps

module lrupr_cell
  import lrupr_pkg::*;
#(
  parameter int SLOT   = 0,
  parameter int SLOT_W = 4,
  parameter int CNT_W  = 5,
  parameter int PAGE_W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CNT_W-1:0]  e_i,
  input  logic [CNT_W-1:0]  fill_idx_i,
  input  logic [PAGE_W-1:0] key_i,
  input  cell_cmd_t         cmd_i,
  input  logic [SLOT_W-1:0] cmd_slot_i,
  input  logic [SLOT_W-1:0] cmd_rank_i,
  input  logic [PAGE_W-1:0] cmd_page_i,
  input  scan_ctl_t         ctl_i,
  input  logic [SLOT_W-1:0] hit_slot_i,
  input  logic [SLOT_W-1:0] hit_rank_i,
  input  logic [SLOT_W-1:0] fill_rank_i,
  input  logic [SLOT_W-1:0] best_rank_i,
  input  logic [SLOT_W-1:0] best_slot_i,
  input  logic [PAGE_W-1:0] best_page_i,
  output scan_ctl_t         ctl_o,
  output logic [SLOT_W-1:0] hit_slot_o,
  output logic [SLOT_W-1:0] hit_rank_o,
  output logic [SLOT_W-1:0] fill_rank_o,
  output logic [SLOT_W-1:0] best_rank_o,
  output logic [SLOT_W-1:0] best_slot_o,
  output logic [PAGE_W-1:0] best_page_o
);

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(SLOT);
  localparam logic [CNT_W-1:0]  MY_CNT  = CNT_W'(SLOT);

  logic [PAGE_W-1:0] page_q;
  logic              valid_q;
  logic [SLOT_W-1:0] rank_q;

  scan_ctl_t         ctl_d, ctl_q;
  logic [SLOT_W-1:0] hit_slot_d, hit_slot_q;
  logic [SLOT_W-1:0] hit_rank_d, hit_rank_q;
  logic [SLOT_W-1:0] fill_rank_d, fill_rank_q;
  logic [SLOT_W-1:0] best_rank_d, best_rank_q;
  logic [SLOT_W-1:0] best_slot_d, best_slot_q;
  logic [PAGE_W-1:0] best_page_d, best_page_q;
  logic              in_range;

  assign in_range = (MY_CNT < e_i);

  always_comb begin
    ctl_d       = ctl_i;
    hit_slot_d  = hit_slot_i;
    hit_rank_d  = hit_rank_i;
    fill_rank_d = fill_rank_i;
    best_rank_d = best_rank_i;
    best_slot_d = best_slot_i;
    best_page_d = best_page_i;
    if (ctl_i.active && in_range) begin
      if (valid_q && (page_q == key_i) && !ctl_i.hit) begin
        ctl_d.hit  = 1'b1;
        hit_slot_d = MY_SLOT;
        hit_rank_d = rank_q;
      end
      if (fill_idx_i == MY_CNT) begin
        fill_rank_d = rank_q;
      end
      if (rank_q >= best_rank_i) begin
        best_rank_d      = rank_q;
        best_slot_d      = MY_SLOT;
        best_page_d      = page_q;
        ctl_d.best_valid = valid_q;
      end
    end
  end

  // scan stage toward the neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_slot_q  <= hit_slot_d;
    hit_rank_q  <= hit_rank_d;
    fill_rank_q <= fill_rank_d;
    best_rank_q <= best_rank_d;
    best_slot_q <= best_slot_d;
    best_page_q <= best_page_d;
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= MY_SLOT;
    end else if (cmd_i.flush) begin
      valid_q <= 1'b0;
      rank_q  <= MY_SLOT;
    end else if (cmd_i.touch) begin
      if (cmd_slot_i == MY_SLOT) begin
        rank_q <= '0;
        if (cmd_i.write) begin
          valid_q <= 1'b1;
        end
      end else if (rank_q < cmd_rank_i) begin
        rank_q <= rank_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.touch && cmd_i.write && (cmd_slot_i == MY_SLOT)) begin
      page_q <= cmd_page_i;
    end
  end

  assign ctl_o       = ctl_q;
  assign hit_slot_o  = hit_slot_q;
  assign hit_rank_o  = hit_rank_q;
  assign fill_rank_o = fill_rank_q;
  assign best_rank_o = best_rank_q;
  assign best_slot_o = best_slot_q;
  assign best_page_o = best_page_q;

endmodule

// ===== dv/lru_page_replacement_unit_test.sv =====
// Testbench for lru_page_replacement_unit: queued page references and frame-count writes,
// a predictor of the LRU frame table, and an in-order check of every result.
// Depends on lrupr_pkg and the RTL of lru_page_replacement_unit.
`timescale 1ns / 1ps

module lru_page_replacement_unit_test;
  import lrupr_pkg::*;

  localparam int FRAMES      = FRAME_COUNT_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TRACE_ITEMS = 1350;

  typedef struct packed {
    logic                   hit;
    logic [SLOT_PORT_W-1:0] slot;
    logic                   evicted;
    logic [PAGE_PORT_W-1:0] evicted_page;
    logic [FAULT_W-1:0]     fault_total;
  } lookup_outcome_t;

  typedef struct packed {
    bit                     frames_write;
    logic [PAGE_PORT_W-1:0] value;
  } trace_entry_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic [PAGE_PORT_W-1:0] page_number_i = '0;
  logic                   result_valid_o;
  logic                   hit_o;
  logic [SLOT_PORT_W-1:0] frame_slot_o;
  logic                   evicted_o;
  logic [PAGE_PORT_W-1:0] evicted_page_o;
  logic [FAULT_W-1:0]     fault_total_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  lru_page_replacement_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .page_number_i  (page_number_i),
    .result_valid_o (result_valid_o),
    .hit_o          (hit_o),
    .frame_slot_o   (frame_slot_o),
    .evicted_o      (evicted_o),
    .evicted_page_o (evicted_page_o),
    .fault_total_o  (fault_total_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // predictor state
  logic [PAGE_PORT_W-1:0] page_in_frame [FRAMES];
  bit                     frame_holds   [FRAMES];
  int                     age_rank      [FRAMES];
  int                     frames_filled;
  logic [FAULT_W-1:0]     fault_tally;
  logic [CFG_W-1:0]       frame_limit;

  trace_entry_t    reference_trace [$];
  lookup_outcome_t outcomes_due [$];

  int mismatches = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int issued = 0;
  int queued_refs = 0;
  int frame_writes = 0;
  int hits_seen = 0;
  int faults_seen = 0;
  int evictions_seen = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void clear_frames();
    for (int s = 0; s < FRAMES; s++) begin
      frame_holds[s] = 1'b0;
      age_rank[s] = s;
    end
    frames_filled = 0;
  endfunction

  function automatic void apply_frames_write(logic [CFG_W-1:0] value);
    frame_limit = value;
    frame_writes++;
    clear_frames();
  endfunction

  function automatic lookup_outcome_t predict_lookup(logic [PAGE_PORT_W-1:0] page);
    lookup_outcome_t o;
    int limit;
    int slot;
    int oldest;
    int rank;
    bit found;
    o = '0;
    found = 1'b0;
    slot = 0;
    if (frame_limit == 0) limit = 1;
    else if (int'(frame_limit) > FRAMES) limit = FRAMES;
    else limit = int'(frame_limit);
    for (int s = 0; s < limit; s++) begin
      if (!found && frame_holds[s] && page_in_frame[s] == page) begin
        found = 1'b1;
        slot = s;
      end
    end
    if (!found) begin
      if (fault_tally != FAULT_MAX) fault_tally++;
      if (frames_filled < limit) begin
        slot = frames_filled;
        frames_filled++;
      end else begin
        oldest = 0;
        for (int s = 0; s < limit; s++) begin
          if (age_rank[s] >= oldest) begin
            oldest = age_rank[s];
            slot = s;
          end
        end
        if (frame_holds[slot]) begin
          o.evicted = 1'b1;
          o.evicted_page = page_in_frame[slot];
        end
      end
      page_in_frame[slot] = page;
      frame_holds[slot] = 1'b1;
    end
    // promote to most recent, age the younger frames
    rank = age_rank[slot];
    for (int s = 0; s < FRAMES; s++) begin
      if (age_rank[s] < rank) age_rank[s]++;
    end
    age_rank[slot] = 0;
    o.hit = found;
    o.slot = slot[SLOT_PORT_W-1:0];
    o.fault_total = fault_tally;
    return o;
  endfunction

  function automatic void add_reference(logic [PAGE_PORT_W-1:0] page);
    trace_entry_t e;
    e.frames_write = 1'b0;
    e.value = page;
    reference_trace.push_back(e);
    queued_refs++;
  endfunction

  function automatic void add_frames_write(logic [CFG_W-1:0] value);
    trace_entry_t e;
    e.frames_write = 1'b1;
    e.value = PAGE_PORT_W'(value);
    reference_trace.push_back(e);
  endfunction

  task automatic check_field(input string field, input logic [FAULT_W-1:0] want,
                             input logic [FAULT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    logic                   next_start;
    logic                   next_cfg;
    logic [PAGE_PORT_W-1:0] next_page;
    logic [CFG_W-1:0]       next_frames;
    bit                     idle_on;
    if (!rst_ni) begin
      start_i <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      next_start = start_i;
      next_page = page_number_i;
      next_cfg = cfg_valid_i;
      next_frames = cfg_data_i;
      if (start_i && !busy_o) begin
        outcomes_due.push_back(predict_lookup(page_number_i));
        next_start = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        apply_frames_write(cfg_data_i);
        next_cfg = 1'b0;
      end
      if (!next_start && !next_cfg && reference_trace.size() > 0) begin
        idle_on = !(issued >= 450 && issued < 750);
        if (gap_left > 0) begin
          gap_left--;
        end else if (reference_trace[0].frames_write) begin
          // write only once every result is in
          if (outcomes_due.size() == 0 && !busy_o) begin
            next_cfg = 1'b1;
            next_frames = reference_trace[0].value[CFG_W-1:0];
            void'(reference_trace.pop_front());
          end
        end else if (idle_on && $urandom_range(0, 99) < 12) begin
          gap_left = $urandom_range(1, 30);
        end else begin
          next_start = 1'b1;
          next_page = reference_trace[0].value;
          void'(reference_trace.pop_front());
          issued++;
        end
      end
      start_i <= next_start;
      page_number_i <= next_page;
      cfg_valid_i <= next_cfg;
      cfg_data_i <= next_frames;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    lookup_outcome_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (outcomes_due.size() == 0) begin
        $display("%0t: unexpected result: hit=%0h slot=%0h evicted=%0h page=%0h faults=%0h",
                 $time, hit_o, frame_slot_o, evicted_o, evicted_page_o, fault_total_o);
        mismatches++;
      end else begin
        want = outcomes_due.pop_front();
        check_field("hit", FAULT_W'(want.hit), FAULT_W'(hit_o));
        check_field("frame_slot", FAULT_W'(want.slot), FAULT_W'(frame_slot_o));
        check_field("evicted", FAULT_W'(want.evicted), FAULT_W'(evicted_o));
        check_field("evicted_page", FAULT_W'(want.evicted_page), FAULT_W'(evicted_page_o));
        check_field("fault_total", want.fault_total, fault_total_o);
        if (want.hit) hits_seen++;
        else faults_seen++;
        if (want.evicted) evictions_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still due", $time, cycle_count,
               outcomes_due.size());
      $display("lru_page_replacement_unit_test: FAIL");
      $finish;
    end
  end

  initial begin
    logic [PAGE_PORT_W-1:0] pool [2*FRAMES+2];
    logic [CFG_W-1:0]       setting;
    logic [CFG_W-1:0]       fixed_settings [5];
    int                     limit;
    int                     pool_size;
    int                     phase_len;
    int                     phase;

    frame_limit = CFG_RESET;
    fault_tally = '0;
    clear_frames();

    // directed: extremes at reset size, single frame, two frames, clamped sizes
    add_reference(16'h0000);
    add_reference(16'hFFFF);
    add_reference(16'h0000);
    add_reference(16'hAAAA);
    add_reference(16'h5555);
    add_reference(16'hFFFF);
    add_frames_write(5'd0);
    add_reference(16'h0007);
    add_reference(16'h0007);
    add_reference(16'h0009);
    add_reference(16'h0007);
    add_frames_write(5'd2);
    add_reference(16'h0001);
    add_reference(16'h0002);
    add_reference(16'h0001);
    add_reference(16'h0003);
    add_reference(16'h0002);
    add_frames_write(5'd31);
    add_reference(16'h8000);
    add_reference(16'h0001);
    add_reference(16'h8000);
    add_frames_write(5'd17);
    add_reference(16'h1234);

    // random phases: working sets around the frame count, plus stray pages
    fixed_settings = '{5'd16, 5'd1, 5'd3, 5'd0, 5'd31};
    phase = 0;
    while (queued_refs < TRACE_ITEMS) begin
      setting = (phase < 5) ? fixed_settings[phase] : CFG_W'($urandom_range(0, 31));
      add_frames_write(setting);
      if (setting == 0) limit = 1;
      else if (int'(setting) > FRAMES) limit = FRAMES;
      else limit = int'(setting);
      pool_size = $urandom_range(1, 2 * limit + 2);
      for (int i = 0; i < pool_size; i++) pool[i] = PAGE_PORT_W'($urandom_range(0, 65535));
      phase_len = $urandom_range(140, 190);
      for (int n = 0; n < phase_len && queued_refs < TRACE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 3)
          pool[$urandom_range(0, pool_size - 1)] = PAGE_PORT_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 99) < 15) add_reference(PAGE_PORT_W'($urandom_range(0, 65535)));
        else add_reference(pool[$urandom_range(0, pool_size - 1)]);
      end
      phase++;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (reference_trace.size() != 0 || start_i || cfg_valid_i || outcomes_due.size() != 0)
      @(posedge clk_i);
    repeat (FRAMES + 4) @(posedge clk_i);

    $display("Checked %0d references: %0d hits, %0d faults, %0d evictions", hits_seen + faults_seen,
             hits_seen, faults_seen, evictions_seen);
    $display("Frame count written %0d times, including 0, 1, 16 and clamped values", frame_writes);
    if (mismatches == 0) begin
      $display("lru_page_replacement_unit_test: PASS");
    end else begin
      $display("lru_page_replacement_unit_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lrupr_pkg.sv
hdl/lrupr_cell.sv
hdl/lru_page_replacement_unit.sv
dv/lru_page_replacement_unit_test.sv
